[rtl/rsa_pkg.sv]
// Shared types, codes and defaults of the region sector allocator.
package rsa_pkg;

    localparam int MAX_SECTORS_DEF  = 4096;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int SLOT_COUNT       = 1024;
    localparam int SLOT_AW          = 10;
    localparam int COUNT_W          = 8;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_STORE  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_LOOKUP    = 3'd0,
        ST_IN_PLACE  = 3'd1,
        ST_REUSED    = 3'd2,
        ST_GROWN     = 3'd3,
        ST_TOO_LARGE = 3'd4,
        ST_FULL      = 3'd5
    } t_status;

    typedef struct packed {
        logic        command;
        logic [4:0]  slot_x;
        logic [4:0]  slot_z;
        logic [19:0] payload_length;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic        present;
        logic [11:0] start_sector;
        logic [7:0]  sector_count;
        logic [7:0]  grown_sectors;
    } t_rsp;

    typedef struct packed {
        logic                 cmd;
        logic                 too_large;
        logic [SLOT_AW-1:0]   slot;
        logic [COUNT_W-1:0]   need;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_CLEAR,
        B_IDLE,
        B_SLOT_RD,
        B_SLOT_EV,
        B_SCAN_RD,
        B_SCAN_EV,
        B_REL_RD,
        B_REL_WR,
        B_MK_RD,
        B_MK_WR,
        B_COMMIT,
        B_EMIT
    } t_back_state;

endpackage

[rtl/region_sector_allocator.sv]
// Top level of the region sector allocator: intake, request queue and execution.
//
//  channel | direction | handshake                         | payload
//  request | in        | i_req_valid / o_req_stall         | i_req (t_req)
//  result  | out       | o_rsp_valid / i_rsp_stall         | o_rsp (t_rsp)
//
// A lookup, a too-large store and an in-place store take their result from the slot
// table read alone. A store that is carried out scans 8-sector free map words from
// sector 0, then releases the old run and marks the new one; a full store only
// scans the free map.
// After reset the slot table is cleared; requests stall then.
// The two-entry queue and the result register let intake continue while a
// result is stalled.
module region_sector_allocator #(
    parameter int MAX_SECTORS  = rsa_pkg::MAX_SECTORS_DEF,
    parameter int SECTOR_BYTES = rsa_pkg::SECTOR_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  rsa_pkg::t_req i_req,
    output logic          o_req_stall,
    output logic          o_rsp_valid,
    output rsa_pkg::t_rsp o_rsp,
    input  logic          i_rsp_stall
);

    logic          clearing, q_full, push, q_valid, pop;
    rsa_pkg::t_job front_job, q_job;

    rsa_front #(.SECTOR_BYTES(SECTOR_BYTES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req_valid),
        .i_req      (i_req),
        .o_req_stall(o_req_stall),
        .i_clearing (clearing),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    rsa_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_job  (q_job),
        .i_pop  (pop)
    );

    rsa_back #(.MAX_SECTORS(MAX_SECTORS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(q_valid),
        .i_job      (q_job),
        .o_job_pop  (pop),
        .o_clearing (clearing),
        .o_rsp_valid(o_rsp_valid),
        .o_rsp      (o_rsp),
        .i_rsp_stall(i_rsp_stall)
    );

endmodule

[rtl/rsa_ram.sv]
// Generic single-port RAM with registered read data.
module rsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/rsa_front.sv]
// Request intake: slot index, sector need by reciprocal multiplication, size check.
module rsa_front #(
    parameter int SECTOR_BYTES = rsa_pkg::SECTOR_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  rsa_pkg::t_req i_req,
    output logic          o_req_stall,
    input  logic          i_clearing,
    input  logic          i_q_full,
    output logic          o_push,
    output rsa_pkg::t_job o_job
);

    localparam logic [31:0] LIMIT = 32'(255 * SECTOR_BYTES);
    localparam int          SB_L  = $clog2(SECTOR_BYTES);
    localparam int          RSH   = 21 + SB_L;
    localparam logic [22:0] RECIP = 23'(((64'd1 << RSH) + 64'(SECTOR_BYTES) - 64'd1)
                                        / 64'(SECTOR_BYTES));

    rsa_pkg::t_front_state r_state, n_state;
    logic [20:0] r_rem;
    logic [7:0]  r_quot;
    logic        r_cmd;
    logic        r_too_large;
    logic [9:0]  r_slot;
    logic [20:0] len_adj;
    logic [63:0] prod;
    logic        take;

    assign len_adj = 21'(i_req.payload_length) + 21'd5;
    assign prod    = 64'(r_rem) * 64'(RECIP);
    assign take    = i_req_valid && !o_req_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsa_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsa_pkg::F_IDLE: begin
                if (take) begin
                    if (i_req.command == rsa_pkg::CMD_STORE
                        && !(32'(len_adj) >= LIMIT)) begin
                        n_state = rsa_pkg::F_DIV;
                    end else begin
                        n_state = rsa_pkg::F_PUSH;
                    end
                end
            end
            rsa_pkg::F_DIV: n_state = rsa_pkg::F_PUSH;
            rsa_pkg::F_PUSH: begin
                if (!i_q_full) begin
                    n_state = rsa_pkg::F_IDLE;
                end
            end
            default: n_state = rsa_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_req_stall = i_clearing || (r_state != rsa_pkg::F_IDLE);
        o_push      = (r_state == rsa_pkg::F_PUSH) && !i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == rsa_pkg::F_IDLE && take) begin
            r_cmd       <= i_req.command;
            r_slot      <= {i_req.slot_z, i_req.slot_x};
            r_rem       <= len_adj;
            r_quot      <= '0;
            r_too_large <= 32'(len_adj) >= LIMIT;
        end else if (r_state == rsa_pkg::F_DIV) begin
            r_quot <= prod[RSH +: 8];
        end
    end

    always_comb begin
        o_job.cmd       = r_cmd;
        o_job.too_large = r_too_large;
        o_job.slot      = r_slot;
        o_job.need      = r_quot + 8'd1;
    end

endmodule

[rtl/rsa_queue.sv]
// Two-entry request queue between intake and execution.
module rsa_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rsa_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output rsa_pkg::t_job o_job,
    input  logic          i_pop
);

    rsa_pkg::t_job r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_job   = r_mem[r_rp];

endmodule

[rtl/rsa_back.sv]
// Execution: slot table, free map scan, release and mark, result register.
module rsa_back #(
    parameter int MAX_SECTORS = rsa_pkg::MAX_SECTORS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  rsa_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_clearing,
    output logic          o_rsp_valid,
    output rsa_pkg::t_rsp o_rsp,
    input  logic          i_rsp_stall
);

    localparam int SW  = $clog2(MAX_SECTORS);
    localparam int UW  = $clog2(MAX_SECTORS + 1);
    localparam int CW  = UW + 9;
    localparam int WD  = (MAX_SECTORS + 7) / 8;
    localparam int WAW = $clog2(WD);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SECTORS);
    localparam int SLOT_AW_L = rsa_pkg::SLOT_AW;

    rsa_pkg::t_back_state r_state, n_state;
    rsa_pkg::t_job        r_job;
    logic [SLOT_AW_L-1:0] r_clr;
    logic [UW-1:0]        r_used;
    logic [SW-1:0]        r_old_s, r_new_s, r_cur_s, r_run_start;
    logic [7:0]           r_old_c, r_cur_c, r_run_len, r_grown;
    logic [WAW-1:0]       r_w;
    logic                 r_grow;
    logic [2:0]           r_status;
    logic                 r_out_valid;
    rsa_pkg::t_rsp        r_out;

    logic                 slot_we;
    logic [SLOT_AW_L-1:0] slot_addr;
    logic [SW+7:0]        slot_wdata, slot_rdata;
    logic                 fm_we;
    logic [7:0]           fm_wdata, fm_rdata;
    logic [7:0]           rel_mask, mk_mask;
    logic [CW-1:0]        base, used_c, old_s_c, old_e_c, new_s_c, new_e_c;
    logic [7:0]           n_run_len;
    logic [SW-1:0]        n_run_start;
    logic                 scan_hit, scan_end, grow_full, out_free, out_load;
    logic [SW+11:0]       start_ext;

    rsa_ram #(.WIDTH(SW + 8), .DEPTH(rsa_pkg::SLOT_COUNT)) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (slot_we),
        .i_addr (slot_addr),
        .i_wdata(slot_wdata),
        .o_rdata(slot_rdata)
    );

    rsa_ram #(.WIDTH(8), .DEPTH(WD)) u_fm_ram (
        .i_clk  (i_clk),
        .i_we   (fm_we),
        .i_addr (r_w),
        .i_wdata(fm_wdata),
        .o_rdata(fm_rdata)
    );

    assign base    = CW'({r_w, 3'b000});
    assign used_c  = CW'(r_used);
    assign old_s_c = CW'(r_old_s);
    assign old_e_c = CW'(r_old_s) + CW'(r_old_c);
    assign new_s_c = CW'(r_new_s);
    assign new_e_c = CW'(r_new_s) + CW'(r_job.need);
    assign out_free = !r_out_valid || !i_rsp_stall;

    // First-fit walk over one free map word; the slot's old run counts as free.
    always_comb begin
        logic [CW-1:0] k;
        logic          fr;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        scan_hit    = 1'b0;
        for (int j = 0; j < 8; j++) begin
            k  = base + CW'(j);
            fr = 1'b0;
            if (!scan_hit && k >= CW'(2) && k < used_c) begin
                fr = fm_rdata[j] || (k >= old_s_c && k < old_e_c);
                if (fr) begin
                    if (n_run_len == 8'd0) begin
                        n_run_start = SW'(k);
                    end
                    n_run_len = n_run_len + 8'd1;
                    if (n_run_len >= r_job.need) begin
                        scan_hit = 1'b1;
                    end
                end else begin
                    n_run_len = 8'd0;
                end
            end
        end
        scan_end  = base + CW'(8) >= used_c;
        grow_full = used_c + CW'(r_job.need) > MAX_C;
    end

    always_comb begin
        logic [CW-1:0] k;
        for (int j = 0; j < 8; j++) begin
            k           = base + CW'(j);
            rel_mask[j] = k >= old_s_c && k < old_e_c && k < used_c;
            mk_mask[j]  = k >= new_s_c && k < new_e_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsa_pkg::B_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rsa_pkg::B_CLEAR: begin
                if (&r_clr) begin
                    n_state = rsa_pkg::B_IDLE;
                end
            end
            rsa_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = rsa_pkg::B_SLOT_RD;
                end
            end
            rsa_pkg::B_SLOT_RD: n_state = rsa_pkg::B_SLOT_EV;
            rsa_pkg::B_SLOT_EV: begin
                if (r_job.cmd == rsa_pkg::CMD_LOOKUP || r_job.too_large
                    || (slot_rdata[SW+7:8] != '0 && slot_rdata[7:0] == r_job.need)) begin
                    n_state = rsa_pkg::B_EMIT;
                end else begin
                    n_state = rsa_pkg::B_SCAN_RD;
                end
            end
            rsa_pkg::B_SCAN_RD: n_state = rsa_pkg::B_SCAN_EV;
            rsa_pkg::B_SCAN_EV: begin
                if (scan_hit) begin
                    n_state = (r_old_c == 8'd0) ? rsa_pkg::B_MK_RD : rsa_pkg::B_REL_RD;
                end else if (scan_end) begin
                    if (grow_full) begin
                        n_state = rsa_pkg::B_EMIT;
                    end else begin
                        n_state = (r_old_c == 8'd0) ? rsa_pkg::B_MK_RD
                                                    : rsa_pkg::B_REL_RD;
                    end
                end else begin
                    n_state = rsa_pkg::B_SCAN_RD;
                end
            end
            rsa_pkg::B_REL_RD: n_state = rsa_pkg::B_REL_WR;
            rsa_pkg::B_REL_WR: begin
                n_state = (base + CW'(8) >= old_e_c) ? rsa_pkg::B_MK_RD
                                                     : rsa_pkg::B_REL_RD;
            end
            rsa_pkg::B_MK_RD: n_state = rsa_pkg::B_MK_WR;
            rsa_pkg::B_MK_WR: begin
                n_state = (base + CW'(8) >= new_e_c) ? rsa_pkg::B_COMMIT
                                                     : rsa_pkg::B_MK_RD;
            end
            rsa_pkg::B_COMMIT: n_state = rsa_pkg::B_EMIT;
            rsa_pkg::B_EMIT: begin
                if (out_free) begin
                    n_state = rsa_pkg::B_IDLE;
                end
            end
            default: n_state = rsa_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_clearing = r_state == rsa_pkg::B_CLEAR;
        o_job_pop  = (r_state == rsa_pkg::B_IDLE) && i_job_valid;
        slot_we    = 1'b0;
        slot_addr  = r_job.slot;
        slot_wdata = {r_new_s, r_job.need};
        fm_we      = 1'b0;
        fm_wdata   = fm_rdata & ~mk_mask;
        out_load   = 1'b0;
        case (r_state)
            rsa_pkg::B_CLEAR: begin
                slot_we    = 1'b1;
                slot_addr  = r_clr;
                slot_wdata = '0;
            end
            rsa_pkg::B_REL_WR: begin
                fm_we    = 1'b1;
                fm_wdata = fm_rdata | rel_mask;
            end
            rsa_pkg::B_MK_WR:  fm_we    = 1'b1;
            rsa_pkg::B_COMMIT: slot_we  = 1'b1;
            rsa_pkg::B_EMIT:   out_load = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_used      <= UW'(2);
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == rsa_pkg::B_CLEAR) begin
                r_clr <= r_clr + SLOT_AW_L'(1);
            end
            if (r_state == rsa_pkg::B_COMMIT && r_grow) begin
                r_used <= r_used + UW'(r_job.need);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            rsa_pkg::B_IDLE: begin
                r_job <= i_job;
            end
            rsa_pkg::B_SLOT_EV: begin
                r_old_s     <= slot_rdata[SW+7:8];
                r_old_c     <= slot_rdata[7:0];
                r_cur_s     <= slot_rdata[SW+7:8];
                r_cur_c     <= slot_rdata[7:0];
                r_grown     <= 8'd0;
                r_w         <= '0;
                r_run_len   <= 8'd0;
                r_run_start <= '0;
                if (r_job.cmd == rsa_pkg::CMD_LOOKUP) begin
                    r_status <= rsa_pkg::ST_LOOKUP;
                end else if (r_job.too_large) begin
                    r_status <= rsa_pkg::ST_TOO_LARGE;
                end else begin
                    r_status <= rsa_pkg::ST_IN_PLACE;
                end
            end
            rsa_pkg::B_SCAN_EV: begin
                r_run_len   <= n_run_len;
                r_run_start <= n_run_start;
                r_w         <= r_w + WAW'(1);
                r_grow      <= !scan_hit;
                r_new_s     <= scan_hit ? n_run_start : SW'(r_used);
                r_status    <= rsa_pkg::ST_FULL;
                if (scan_hit || scan_end) begin
                    r_w <= (r_old_c == 8'd0)
                         ? WAW'((scan_hit ? n_run_start : SW'(r_used)) >> 3)
                         : WAW'(r_old_s >> 3);
                end
            end
            rsa_pkg::B_REL_WR: begin
                r_w <= (base + CW'(8) >= old_e_c) ? WAW'(r_new_s >> 3) : r_w + WAW'(1);
            end
            rsa_pkg::B_MK_WR: begin
                r_w <= r_w + WAW'(1);
            end
            rsa_pkg::B_COMMIT: begin
                r_cur_s  <= r_new_s;
                r_cur_c  <= r_job.need;
                r_status <= r_grow ? rsa_pkg::ST_GROWN : rsa_pkg::ST_REUSED;
                r_grown  <= r_grow ? r_job.need : 8'd0;
            end
            default: ;
        endcase
    end

    assign start_ext = {12'd0, r_cur_s};

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.status        <= r_status;
            r_out.present       <= (r_cur_s != '0) || (r_cur_c != 8'd0);
            r_out.start_sector  <= start_ext[11:0];
            r_out.sector_count  <= r_cur_c;
            r_out.grown_sectors <= r_grown;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

endmodule

[rtl/rsa_checker.sv]
// Port-level checks of the region sector allocator and their binding.
module rsa_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_rsp_valid,
    input rsa_pkg::t_rsp o_rsp,
    input logic          i_rsp_stall
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && i_rsp_stall |=> o_rsp_valid && $stable(o_rsp))
        else $error("stalled result changed");

    a_grown_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status != rsa_pkg::ST_GROWN |-> o_rsp.grown_sectors == 8'd0)
        else $error("growth reported without a grown status");

    a_grown_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.status == rsa_pkg::ST_GROWN
        |-> o_rsp.grown_sectors == o_rsp.sector_count && o_rsp.grown_sectors != 8'd0)
        else $error("grown sectors differ from the new run");

    a_placed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == rsa_pkg::ST_IN_PLACE
                        || o_rsp.status == rsa_pkg::ST_REUSED
                        || o_rsp.status == rsa_pkg::ST_GROWN)
        |-> o_rsp.present && o_rsp.sector_count != 8'd0)
        else $error("stored slot reported empty");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("result valid after reset");

endmodule

bind region_sector_allocator rsa_checker u_rsa_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_rsp_valid(o_rsp_valid),
    .o_rsp      (o_rsp),
    .i_rsp_stall(i_rsp_stall)
);

[tb/region_sector_allocator_tb.sv]
// Self-checking testbench for the region sector allocator with a built-in allocation predictor.
module region_sector_allocator_tb;

    typedef struct {
        rsa_pkg::t_req req;
        bit            hold;
        bit            calm;
    } t_item;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_req_valid = 1'b0;
    rsa_pkg::t_req i_req = '0;
    logic          o_req_stall;
    logic          o_rsp_valid;
    rsa_pkg::t_rsp o_rsp;
    logic          i_rsp_stall = 1'b0;

    t_item         pending_reqs[$];
    rsa_pkg::t_rsp expected_rsps[$];
    bit            sector_free[rsa_pkg::MAX_SECTORS_DEF];
    int            slot_start[rsa_pkg::SLOT_COUNT];
    int            slot_count[rsa_pkg::SLOT_COUNT];
    int            store_size;
    int            mismatches = 0;
    int            idle_cycles = 0;
    int            req_gap = 0;
    int            rsp_wait = 0;
    bit            calm_mode = 1'b0;

    region_sector_allocator dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic rsa_pkg::t_rsp slot_entry(rsa_pkg::t_status st, int slot, int grown);
        rsa_pkg::t_rsp r;
        r.status        = st;
        r.present       = (slot_start[slot] != 0 || slot_count[slot] != 0);
        r.start_sector  = slot_start[slot][11:0];
        r.sector_count  = slot_count[slot][7:0];
        r.grown_sectors = grown[7:0];
        return r;
    endfunction

    function automatic rsa_pkg::t_rsp allocate(rsa_pkg::t_req q);
        int slot, need, old_s, old_c, run_s, run_l;
        bit fr;
        slot = q.slot_x + 32 * q.slot_z;
        if (q.command == rsa_pkg::CMD_LOOKUP) return slot_entry(rsa_pkg::ST_LOOKUP, slot, 0);
        need = (int'(q.payload_length) + 5) / rsa_pkg::SECTOR_BYTES_DEF + 1;
        if (need >= 256) return slot_entry(rsa_pkg::ST_TOO_LARGE, slot, 0);
        old_s = slot_start[slot];
        old_c = slot_count[slot];
        if (old_s != 0 && old_c == need) return slot_entry(rsa_pkg::ST_IN_PLACE, slot, 0);
        run_s = 0;
        run_l = 0;
        for (int i = 2; i < store_size && i < rsa_pkg::MAX_SECTORS_DEF; i++) begin
            fr = sector_free[i] || (i >= old_s && i - old_s < old_c);
            if (fr) begin
                if (run_l == 0) run_s = i;
                run_l++;
                if (run_l >= need) break;
            end else begin
                run_l = 0;
            end
        end
        if (run_l < need && store_size + need > rsa_pkg::MAX_SECTORS_DEF)
            return slot_entry(rsa_pkg::ST_FULL, slot, 0);
        for (int i = 0; i < old_c; i++)
            if (old_s + i < store_size) sector_free[old_s + i] = 1'b1;
        if (run_l >= need) begin
            for (int i = 0; i < need; i++) sector_free[run_s + i] = 1'b0;
            slot_start[slot] = run_s;
            slot_count[slot] = need;
            return slot_entry(rsa_pkg::ST_REUSED, slot, 0);
        end
        run_s = store_size;
        for (int i = 0; i < need; i++) sector_free[run_s + i] = 1'b0;
        store_size += need;
        slot_start[slot] = run_s;
        slot_count[slot] = need;
        return slot_entry(rsa_pkg::ST_GROWN, slot, need);
    endfunction

    task automatic add_req(rsa_pkg::t_cmd c, int x, int z, int len,
                           bit hold = 1'b0, bit calm = 1'b0);
        t_item it;
        it.req.command        = c;
        it.req.slot_x         = x[4:0];
        it.req.slot_z         = z[4:0];
        it.req.payload_length = len[19:0];
        it.hold = hold;
        it.calm = calm;
        pending_reqs.insert(pending_reqs.size(), it);
    endtask

    always @(posedge i_clk) begin
        t_item it;
        bit held;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            held = i_req_valid && o_req_stall;
            if (i_req_valid && !o_req_stall)
                expected_rsps.insert(expected_rsps.size(), allocate(i_req));
            if (!held) begin
                if (req_gap > 0) begin
                    req_gap <= req_gap - 1;
                    i_req_valid <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             !(pending_reqs[0].hold && expected_rsps.size() > 0)) begin
                    it = pending_reqs.pop_front();
                    calm_mode <= it.calm;
                    i_req <= it.req;
                    i_req_valid <= 1'b1;
                    req_gap <= it.calm ? 0 : $urandom_range(0, 5);
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        rsa_pkg::t_rsp exp_rsp;
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %p", o_rsp);
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (o_rsp.status !== exp_rsp.status || o_rsp.present !== exp_rsp.present ||
                        o_rsp.start_sector !== exp_rsp.start_sector ||
                        o_rsp.sector_count !== exp_rsp.sector_count ||
                        o_rsp.grown_sectors !== exp_rsp.grown_sectors) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", exp_rsp, o_rsp);
                    end
                end
                rsp_wait = calm_mode ? 0 : $urandom_range(0, 5);
            end else if (o_rsp_valid && rsp_wait > 0) begin
                rsp_wait--;
            end
            i_rsp_stall <= (rsp_wait > 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && !o_req_stall) || (o_rsp_valid && !i_rsp_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("region_sector_allocator_tb NOT OK");
            $finish;
        end
    end

    initial begin
        int x, z, len, k;
        for (int i = 0; i < rsa_pkg::MAX_SECTORS_DEF; i++) sector_free[i] = (i >= 2);
        for (int i = 0; i < rsa_pkg::SLOT_COUNT; i++) begin
            slot_start[i] = 0;
            slot_count[i] = 0;
        end
        store_size = 2;

        add_req(rsa_pkg::CMD_LOOKUP, 0, 0, 0);
        add_req(rsa_pkg::CMD_STORE, 31, 31, 0);
        add_req(rsa_pkg::CMD_STORE, 31, 31, 4090);
        add_req(rsa_pkg::CMD_STORE, 31, 31, 4091);
        add_req(rsa_pkg::CMD_STORE, 0, 0, 1044474);
        add_req(rsa_pkg::CMD_STORE, 1, 0, 1044475);
        add_req(rsa_pkg::CMD_STORE, 2, 0, 1048575);
        add_req(rsa_pkg::CMD_STORE, 31, 31, 100);
        add_req(rsa_pkg::CMD_STORE, 0, 31, 8000);
        add_req(rsa_pkg::CMD_LOOKUP, 31, 31, 1048575);
        add_req(rsa_pkg::CMD_STORE, 0, 0, 10);
        add_req(rsa_pkg::CMD_STORE, 5, 5, 300000);
        add_req(rsa_pkg::CMD_LOOKUP, 0, 0, 0);
        add_req(rsa_pkg::CMD_LOOKUP, 1, 0, 0);
        add_req(rsa_pkg::CMD_LOOKUP, 5, 5, 0, 1'b1);

        for (int n = 0; n < 1700; n++) begin
            k = $urandom_range(0, 99);
            if (k < 85) begin
                x = $urandom_range(0, 3);
                z = $urandom_range(0, 3);
            end else begin
                x = $urandom_range(0, 31);
                z = $urandom_range(0, 31);
            end
            k = $urandom_range(0, 99);
            if (k < 80) len = $urandom_range(0, 20000);
            else if (k < 95) len = $urandom_range(0, 200000);
            else len = $urandom_range(0, 1048575);
            add_req($urandom_range(0, 99) < 30 ? rsa_pkg::CMD_LOOKUP : rsa_pkg::CMD_STORE,
                    x, z, len, n % 400 == 399, (n / 150) % 4 == 3);
        end

        for (int n = 0; n < 20; n++) add_req(rsa_pkg::CMD_STORE, n, 30, 1044474);
        add_req(rsa_pkg::CMD_STORE, 31, 29, 1044474);
        add_req(rsa_pkg::CMD_STORE, 30, 29, 0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || i_req_valid)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatches == 0 && expected_rsps.size() == 0) begin
            $display("region_sector_allocator_tb OK");
        end else begin
            $display("region_sector_allocator_tb NOT OK");
        end
        $finish;
    end
endmodule
